FILE: rtl/core/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared codes and controller/datapath interface types of the dedup champion
// scorer.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_CHOOSE = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
    localparam logic [1:0] STATUS_LIST_FULL  = 2'd2;

    localparam logic [8:0] NO_CHAMP  = 9'd256;
    localparam logic [6:0] SCORE_MAX = 7'd127;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic exec_op;
        logic scan_start;
        logic key_read;
        logic scan_next;
        logic len_read;
        logic app_hit;
        logic app_new;
        logic set_table_full;
        logic set_list_full;
        logic slot_next;
        logic print_read;
        logic list_init;
        logic list_read;
        logic list_next;
        logic score_read;
        logic bump;
        logic found_set;
        logic undo_read;
        logic undo_next;
        logic undo_dec;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       scan_end;
        logic       key_match;
        logic       table_full;
        logic       list_full;
        logic       list_end;
        logic       undo_end;
        logic       slot_end;
        logic       slot_found;
        logic       id_live;
        logic       id_is_prev;
    } sts_t;

endpackage

FILE: rtl/core/dcs_datapath.sv
// ----------------------------------------------------------------------------
// dcs_datapath
// Hook table, candidate lists, incoming store, scores and walk counters.
// ----------------------------------------------------------------------------
module dcs_datapath #(
    parameter int HOOK_ENTRIES    = 256,
    parameter int LIST_DEPTH      = 16,
    parameter int CANDIDATE_COUNT = 256,
    parameter int INCOMING_DEPTH  = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    opcode,
    input  logic [63:0]   fingerprint,
    input  logic [7:0]    candidate_id,
    input  logic [5:0]    slot,
    input  logic [6:0]    incoming_count,
    input  logic [8:0]    last_champion,
    input  dcs_pkg::cmd_t cmd,
    output dcs_pkg::sts_t sts,
    output logic [1:0]    status,
    output logic [8:0]    champion,
    output logic [6:0]    champion_score
);
    import dcs_pkg::*;

    localparam int HW        = $clog2(HOOK_ENTRIES);
    localparam int EW        = $clog2(HOOK_ENTRIES + 1);
    localparam int KW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LW        = $clog2(LIST_DEPTH + 1);
    localparam int IW        = (INCOMING_DEPTH > 1) ? $clog2(INCOMING_DEPTH) : 1;
    localparam int NW        = $clog2(INCOMING_DEPTH + 1);
    localparam int CW        = $clog2(CANDIDATE_COUNT);
    localparam int LIST_SIZE = HOOK_ENTRIES * LIST_DEPTH;
    localparam int LAW       = $clog2(LIST_SIZE);

    // memories
    logic [63:0]   key_mem   [HOOK_ENTRIES];
    logic [LW-1:0] len_mem   [HOOK_ENTRIES];
    logic [7:0]    list_mem  [LIST_SIZE];
    logic [63:0]   print_mem [INCOMING_DEPTH];
    logic [6:0]    score_mem [CANDIDATE_COUNT];

    // captured request
    logic [1:0]    op_reg;
    logic [63:0]   key_reg;
    logic [7:0]    id_reg;
    logic [5:0]    slot_reg;
    logic [NW-1:0] count_reg;
    logic [8:0]    prev_reg;

    // read data
    logic [63:0]   key_rd_reg;
    logic [LW-1:0] len_rd_reg;
    logic [7:0]    list_rd_reg;
    logic [63:0]   print_rd_reg;
    logic [6:0]    score_rd_reg;

    // control state
    logic [EW-1:0] hook_count_reg;
    logic [EW-1:0] e_reg;
    logic [NW-1:0] n_reg;
    logic [LW-1:0] k_reg;
    logic [LW-1:0] b_reg;
    logic [CANDIDATE_COUNT-1:0] del_reg;
    logic [CANDIDATE_COUNT-1:0] score_vld_reg;
    logic [INCOMING_DEPTH-1:0]  found_reg;
    logic          have_lead_reg;
    logic [7:0]    lead_reg;
    logic [6:0]    lead_score_reg;
    logic [1:0]    status_reg;

    logic [HW-1:0]  e_idx;
    logic [IW-1:0]  n_idx;
    logic [KW-1:0]  k_idx;
    logic [KW-1:0]  b_idx;
    logic [CW-1:0]  cand_idx;
    logic [LAW-1:0] list_base;
    logic [LAW-1:0] list_raddr;
    logic [LAW-1:0] list_waddr;
    logic [63:0]    probe;
    logic [6:0]     score_cur;
    logic [6:0]     bump_val;
    logic [6:0]     dec_val;

    assign e_idx      = e_reg[HW-1:0];
    assign n_idx      = n_reg[IW-1:0];
    assign k_idx      = k_reg[KW-1:0];
    assign b_idx      = b_reg[KW-1:0];
    assign cand_idx   = CW'(list_rd_reg);
    assign list_base  = LAW'(32'(e_idx) * LIST_DEPTH);
    assign list_raddr = list_base + LAW'(cmd.undo_read ? b_idx : k_idx);
    assign list_waddr = list_base + (cmd.app_hit ? LAW'(len_rd_reg[KW-1:0]) : LAW'(0));
    assign probe      = (op_reg == OP_CHOOSE) ? print_rd_reg : key_reg;
    assign score_cur  = score_vld_reg[cand_idx] ? score_rd_reg : 7'd0;
    assign bump_val   = (score_cur == SCORE_MAX) ? SCORE_MAX : score_cur + 7'd1;
    assign dec_val    = score_cur - 7'd1;

    always_comb
    begin
        sts.op         = op_reg;
        sts.scan_end   = (e_reg == hook_count_reg);
        sts.key_match  = (key_rd_reg == probe);
        sts.table_full = (hook_count_reg == EW'(HOOK_ENTRIES));
        sts.list_full  = (len_rd_reg >= LW'(LIST_DEPTH));
        sts.list_end   = (k_reg == len_rd_reg);
        sts.undo_end   = (b_reg == k_reg);
        sts.slot_end   = (n_reg == count_reg);
        sts.slot_found = found_reg[n_idx];
        sts.id_live    = (32'(list_rd_reg) < CANDIDATE_COUNT) && !del_reg[cand_idx];
        sts.id_is_prev = ({1'b0, list_rd_reg} == prev_reg);
    end

    // request capture and read data
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            key_reg  <= fingerprint;
            id_reg   <= candidate_id;
            slot_reg <= slot;
            prev_reg <= last_champion;
            if (32'(incoming_count) > INCOMING_DEPTH)
                count_reg <= NW'(INCOMING_DEPTH);
            else
                count_reg <= NW'(incoming_count);
        end
        if (cmd.key_read)
            key_rd_reg <= key_mem[e_idx];
        if (cmd.len_read)
            len_rd_reg <= len_mem[e_idx];
        if (cmd.list_read || cmd.undo_read)
            list_rd_reg <= list_mem[list_raddr];
        if (cmd.print_read)
            print_rd_reg <= print_mem[n_idx];
        if (cmd.score_read)
            score_rd_reg <= score_mem[cand_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_new)
            key_mem[e_idx] <= key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_new)
            len_mem[e_idx] <= LW'(1);
        else if (cmd.app_hit)
            len_mem[e_idx] <= len_rd_reg + LW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_new || cmd.app_hit)
            list_mem[list_waddr] <= id_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && op_reg == OP_WRITE && 32'(slot_reg) < INCOMING_DEPTH)
            print_mem[IW'(slot_reg)] <= key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bump)
            score_mem[cand_idx] <= bump_val;
        else if (cmd.undo_dec && score_cur != 7'd0)
            score_mem[cand_idx] <= dec_val;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status <= status_reg;
            if (op_reg == OP_CHOOSE && have_lead_reg)
            begin
                champion       <= {1'b0, lead_reg};
                champion_score <= lead_score_reg;
            end
            else
            begin
                champion       <= NO_CHAMP;
                champion_score <= 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hook_count_reg <= '0;
            e_reg          <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
            b_reg          <= '0;
            del_reg        <= '0;
            score_vld_reg  <= '0;
            found_reg      <= '0;
            have_lead_reg  <= 1'b0;
            lead_reg       <= '0;
            lead_score_reg <= '0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            if (cmd.accept)
            begin
                status_reg <= STATUS_OK;
                e_reg      <= '0;
                n_reg      <= '0;
                if (opcode == OP_CHOOSE)
                begin
                    score_vld_reg <= '0;
                    have_lead_reg <= 1'b0;
                end
            end
            if (cmd.exec_op)
            begin
                if (op_reg == OP_DELETE && 32'(id_reg) < CANDIDATE_COUNT)
                    del_reg[CW'(id_reg)] <= 1'b1;
                if (op_reg == OP_WRITE && 32'(slot_reg) < INCOMING_DEPTH)
                    found_reg[IW'(slot_reg)] <= 1'b0;
            end
            if (cmd.scan_start)
                e_reg <= '0;
            if (cmd.scan_next)
                e_reg <= e_reg + EW'(1);
            if (cmd.app_new)
                hook_count_reg <= hook_count_reg + EW'(1);
            if (cmd.set_table_full)
                status_reg <= STATUS_TABLE_FULL;
            if (cmd.set_list_full)
                status_reg <= STATUS_LIST_FULL;
            if (cmd.slot_next)
                n_reg <= n_reg + NW'(1);
            if (cmd.list_init)
                k_reg <= '0;
            if (cmd.list_next)
                k_reg <= k_reg + LW'(1);
            if (cmd.found_set)
            begin
                found_reg[n_idx] <= 1'b1;
                b_reg            <= '0;
            end
            if (cmd.undo_next)
                b_reg <= b_reg + LW'(1);
            if (cmd.bump)
            begin
                score_vld_reg[cand_idx] <= 1'b1;
                // first strictly higher score takes the lead
                if (!have_lead_reg || bump_val > lead_score_reg)
                begin
                    have_lead_reg  <= 1'b1;
                    lead_reg       <= list_rd_reg;
                    lead_score_reg <= bump_val;
                end
            end
            if (cmd.undo_dec && have_lead_reg && list_rd_reg == lead_reg
                && score_cur != 7'd0)
                lead_score_reg <= dec_val;
        end
    end

endmodule

FILE: rtl/core/dcs_ctrl.sv
// ----------------------------------------------------------------------------
// dcs_ctrl
// Sequencer for append lookup, list walk, undo and result hand-off.
// ----------------------------------------------------------------------------
module dcs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  dcs_pkg::sts_t sts,
    output dcs_pkg::cmd_t cmd
);
    import dcs_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CMP = 4'd3;
    localparam logic [3:0] S_LEN      = 4'd4;
    localparam logic [3:0] S_SLOT     = 4'd5;
    localparam logic [3:0] S_LIST_RD  = 4'd6;
    localparam logic [3:0] S_LIST_CHK = 4'd7;
    localparam logic [3:0] S_BUMP     = 4'd8;
    localparam logic [3:0] S_UNDO_RD  = 4'd9;
    localparam logic [3:0] S_UNDO_CHK = 4'd10;
    localparam logic [3:0] S_UNDO_DN  = 4'd11;
    localparam logic [3:0] S_FINISH   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (sts.op == OP_APPEND)
                    state_next = S_SCAN_RD;
                else if (sts.op == OP_CHOOSE)
                    state_next = S_SLOT;
                else
                begin
                    cmd.exec_op = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_SCAN_RD:
            begin
                priority if (!sts.scan_end)
                begin
                    cmd.key_read = 1'b1;
                    state_next   = S_SCAN_CMP;
                end
                else if (sts.op == OP_CHOOSE)
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_SLOT;
                end
                else if (sts.table_full)
                begin
                    cmd.set_table_full = 1'b1;
                    state_next         = S_FINISH;
                end
                else
                begin
                    // new hook goes to the first free entry
                    cmd.app_new = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_SCAN_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.len_read = 1'b1;
                    state_next   = S_LEN;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_LEN:
            begin
                priority if (sts.op == OP_CHOOSE)
                begin
                    cmd.list_init = 1'b1;
                    state_next    = S_LIST_RD;
                end
                else if (sts.list_full)
                begin
                    cmd.set_list_full = 1'b1;
                    state_next        = S_FINISH;
                end
                else
                begin
                    cmd.app_hit = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_SLOT:
            begin
                priority if (sts.slot_end)
                    state_next = S_FINISH;
                else if (sts.slot_found)
                    cmd.slot_next = 1'b1;
                else
                begin
                    cmd.print_read = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN_RD;
                end
            end
            S_LIST_RD:
            begin
                if (sts.list_end)
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_SLOT;
                end
                else
                begin
                    cmd.list_read = 1'b1;
                    state_next    = S_LIST_CHK;
                end
            end
            S_LIST_CHK:
            begin
                priority if (!sts.id_live)
                begin
                    cmd.list_next = 1'b1;
                    state_next    = S_LIST_RD;
                end
                else if (sts.id_is_prev)
                begin
                    // previous champion: mark found and take back earlier bumps
                    cmd.found_set = 1'b1;
                    state_next    = S_UNDO_RD;
                end
                else
                begin
                    cmd.score_read = 1'b1;
                    state_next     = S_BUMP;
                end
            end
            S_BUMP:
            begin
                cmd.bump      = 1'b1;
                cmd.list_next = 1'b1;
                state_next    = S_LIST_RD;
            end
            S_UNDO_RD:
            begin
                if (sts.undo_end)
                begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_SLOT;
                end
                else
                begin
                    cmd.undo_read = 1'b1;
                    state_next    = S_UNDO_CHK;
                end
            end
            S_UNDO_CHK:
            begin
                if (sts.id_live)
                begin
                    cmd.score_read = 1'b1;
                    state_next     = S_UNDO_DN;
                end
                else
                begin
                    cmd.undo_next = 1'b1;
                    state_next    = S_UNDO_RD;
                end
            end
            S_UNDO_DN:
            begin
                cmd.undo_dec  = 1'b1;
                cmd.undo_next = 1'b1;
                state_next    = S_UNDO_RD;
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/dedup_champion_scorer.sv
// ----------------------------------------------------------------------------
// dedup_champion_scorer
// Hook table of fingerprint -> candidate lists with champion scoring.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready with opcode, fingerprint, candidate_id,
// slot, incoming_count and last_champion; every request yields one result on
// out_valid/out_ready carrying status, champion and champion_score.
// One request is processed at a time. Delete and slot write are done in
// S_EXEC and then go to the result register. An append scans the used hook
// entries. A choose, per unfound slot, scans the hook entries, walks the
// list and scores its live entries, and on meeting the last champion
// rewalks the earlier entries to take back their scores; the key, list and
// score memories are read one entry at a time.
// A new request is taken while the previous result still waits; only the
// hand-off of the next result stalls when the receiver holds out_ready low.
// Reset empties the hook table, deleted marks, found flags and scores at once.
// ----------------------------------------------------------------------------
module dedup_champion_scorer #(
    parameter int HOOK_ENTRIES    = 256,
    parameter int LIST_DEPTH      = 16,
    parameter int CANDIDATE_COUNT = 256,
    parameter int INCOMING_DEPTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] fingerprint,
    input  logic [7:0]  candidate_id,
    input  logic [5:0]  slot,
    input  logic [6:0]  incoming_count,
    input  logic [8:0]  last_champion,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [8:0]  champion,
    output logic [6:0]  champion_score
);
    import dcs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dcs_datapath #(
        .HOOK_ENTRIES    (HOOK_ENTRIES),
        .LIST_DEPTH      (LIST_DEPTH),
        .CANDIDATE_COUNT (CANDIDATE_COUNT),
        .INCOMING_DEPTH  (INCOMING_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .opcode         (opcode),
        .fingerprint    (fingerprint),
        .candidate_id   (candidate_id),
        .slot           (slot),
        .incoming_count (incoming_count),
        .last_champion  (last_champion),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .champion       (champion),
        .champion_score (champion_score)
    );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives append, delete, slot-write and choose requests into the dedup
// champion scorer and checks each result against an in-bench scoring model or a fixed expected value.
// ----------------------------------------------------------------------------
module testbench;
    import dcs_pkg::*;

    localparam int HOOKS    = 256;
    localparam int DEPTH    = 16;
    localparam int IDS      = 256;
    localparam int SLOTS    = 64;
    localparam int POOL     = 14;
    localparam int N_RANDOM = 260;
    localparam logic [63:0] SAT_KEY = 64'h5A5A_C3C3_0F0F_9669;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] print;
        logic [7:0]  id;
        logic [5:0]  slot;
        logic [6:0]  count;
        logic [8:0]  prev;
        bit          typed;
        logic [1:0]  t_status;
        logic [8:0]  t_champ;
        logic [6:0]  t_score;
    } request_t;

    typedef struct {
        logic [1:0] status;
        logic [8:0] champ;
        logic [6:0] score;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [63:0] fingerprint;
    logic [7:0]  candidate_id;
    logic [5:0]  slot;
    logic [6:0]  incoming_count;
    logic [8:0]  last_champion;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [8:0]  champion;
    logic [6:0]  champion_score;

    // scoring model state
    logic [63:0] m_keys [HOOKS];
    bit          m_used [HOOKS];
    logic [7:0]  m_lists [HOOKS][DEPTH];
    int          m_len [HOOKS];
    bit          m_dead [IDS];
    logic [63:0] m_prints [SLOTS];
    bit          m_found [SLOTS];
    int          m_score [IDS];

    outcome_t    awaited[$];
    logic [63:0] key_pool [POOL];
    int          errors;
    bit          want_hold;
    int          burst_left;

    dedup_champion_scorer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .fingerprint    (fingerprint),
        .candidate_id   (candidate_id),
        .slot           (slot),
        .incoming_count (incoming_count),
        .last_champion  (last_champion),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .champion       (champion),
        .champion_score (champion_score)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int find_hook(logic [63:0] key);
        for (int e = 0; e < HOOKS; e++)
            if (m_used[e] && m_keys[e] == key)
                return e;
        return -1;
    endfunction

    function automatic bit is_live(int id);
        return id < IDS && !m_dead[id];
    endfunction

    function automatic logic [1:0] model_append(logic [63:0] key, logic [7:0] id);
        int e;
        e = find_hook(key);
        if (e < 0)
        begin
            for (e = 0; e < HOOKS; e++)
                if (!m_used[e])
                    break;
            if (e >= HOOKS)
                return STATUS_TABLE_FULL;
            m_used[e] = 1'b1;
            m_keys[e] = key;
            m_len[e]  = 0;
        end
        if (m_len[e] >= DEPTH)
            return STATUS_LIST_FULL;
        m_lists[e][m_len[e]] = id;
        m_len[e]++;
        return STATUS_OK;
    endfunction

    function automatic outcome_t model_choose(int count, int prev);
        outcome_t r;
        bit       have_lead;
        int       lead;
        int       e;
        int       id;
        int       back;
        have_lead = 1'b0;
        lead = 0;
        r.status = STATUS_OK;
        r.champ  = NO_CHAMP;
        r.score  = '0;
        foreach (m_score[i])
            m_score[i] = 0;
        if (count > SLOTS)
            count = SLOTS;
        for (int n = 0; n < count; n++)
        begin
            if (m_found[n])
                continue;
            e = find_hook(m_prints[n]);
            if (e < 0)
                continue;
            for (int k = 0; k < m_len[e]; k++)
            begin
                id = m_lists[e][k];
                if (!is_live(id))
                    continue;
                if (id == prev)
                begin
                    // take back what the earlier entries of this list added
                    m_found[n] = 1'b1;
                    for (int b = 0; b < k; b++)
                    begin
                        back = m_lists[e][b];
                        if (is_live(back) && m_score[back] > 0)
                            m_score[back]--;
                    end
                    break;
                end
                if (m_score[id] < SCORE_MAX)
                    m_score[id]++;
                if (!have_lead || m_score[id] > m_score[lead])
                begin
                    have_lead = 1'b1;
                    lead = id;
                end
            end
        end
        if (have_lead)
        begin
            r.champ = 9'(lead);
            r.score = 7'(m_score[lead]);
        end
        return r;
    endfunction

    function automatic outcome_t model_step(request_t q);
        outcome_t r;
        r.status = STATUS_OK;
        r.champ  = NO_CHAMP;
        r.score  = '0;
        case (q.op)
            OP_APPEND: r.status = model_append(q.print, q.id);
            OP_DELETE: m_dead[q.id] = 1'b1;
            OP_WRITE:
            begin
                m_prints[q.slot] = q.print;
                m_found[q.slot]  = 1'b0;
            end
            default:   r = model_choose(q.count, q.prev);
        endcase
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic request_t mk(logic [1:0] op, logic [63:0] print, int id, int sl,
                                    int count, int prev);
        request_t q;
        q.op = op; q.print = print; q.id = 8'(id); q.slot = 6'(sl);
        q.count = 7'(count); q.prev = 9'(prev); q.typed = 1'b0;
        q.t_status = STATUS_OK; q.t_champ = NO_CHAMP; q.t_score = '0;
        return q;
    endfunction

    function automatic request_t mk_typed(request_t q, logic [1:0] st, logic [8:0] ch,
                                          logic [6:0] sc);
        q.typed = 1'b1; q.t_status = st; q.t_champ = ch; q.t_score = sc;
        return q;
    endfunction

    // offer one request, hold it until taken, then record the outcome
    task automatic send(request_t q);
        outcome_t r;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
        end
        else
            burst_left--;
        in_valid       <= 1'b1;
        opcode         <= q.op;
        fingerprint    <= q.print;
        candidate_id   <= q.id;
        slot           <= q.slot;
        incoming_count <= q.count;
        last_champion  <= q.prev;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = model_step(q);
        if (q.typed)
        begin
            r.status = q.t_status;
            r.champ  = q.t_champ;
            r.score  = q.t_score;
        end
        awaited.push_back(r);
    endtask

    function automatic request_t random_request();
        request_t q;
        int       pick;
        int       id;
        int       prev;
        int       count;
        logic [63:0] print;
        pick  = $urandom_range(0, 99);
        print = $urandom_range(0, 7) == 0 ? {$urandom, $urandom}
                                          : key_pool[$urandom_range(0, POOL - 1)];
        id    = $urandom_range(0, 5) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 11);
        case ($urandom_range(0, 3))
            0:       prev = $urandom_range(256, 511);
            1:       prev = $urandom_range(0, 255);
            default: prev = $urandom_range(0, 11);
        endcase
        count = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 16);
        if (pick < 40)
            q = mk(OP_APPEND, print, id, $urandom_range(0, 63), count, prev);
        else if (pick < 45)
            q = mk(OP_DELETE, print, $urandom_range(0, 255), $urandom_range(0, 63), count, prev);
        else if (pick < 75)
            q = mk(OP_WRITE, print, id, $urandom_range(0, 63), count, prev);
        else
            q = mk(OP_CHOOSE, print, id, $urandom_range(0, 63), count, prev);
        return q;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                w = awaited.pop_front();
                if (status !== w.status)
                    report("status", status, w.status);
                if (champion !== w.champ)
                    report("champion", champion, w.champ);
                if (champion_score !== w.score)
                    report("champion_score", champion_score, w.score);
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int phase;
        hold_left = 0;
        phase = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (want_hold)
            begin
                want_hold = 1'b0;
                hold_left = 400;
            end
            phase = (phase + 1) % 64;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (phase < 20)
                out_ready <= 1'b1;
            else
                out_ready <= $urandom_range(0, 2) != 0;
        end
    end

    initial
    begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        request_t directed[$];
        int       waited;
        errors = 0;
        want_hold = 1'b0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_APPEND;
        fingerprint = '0;
        candidate_id = '0;
        slot = '0;
        incoming_count = '0;
        last_champion = NO_CHAMP;
        foreach (m_used[i])
        begin
            m_used[i] = 1'b0;
            m_len[i] = 0;
        end
        foreach (m_dead[i])
        begin
            m_dead[i] = 1'b0;
            m_score[i] = 0;
        end
        foreach (m_found[i])
            m_found[i] = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            key_pool[i] = {$urandom, $urandom};

        directed = '{
            mk_typed(mk(OP_CHOOSE, '0, 0, 0, 0, 256), STATUS_OK, NO_CHAMP, 7'd0),
            mk_typed(mk(OP_APPEND, key_pool[2], 0, 0, 0, 0), STATUS_OK, NO_CHAMP, 7'd0),
            mk(OP_APPEND, key_pool[2], 255, 63, 127, 511),
            mk(OP_APPEND, key_pool[2], 3, 0, 0, 0),
            mk(OP_APPEND, key_pool[2], 3, 0, 0, 0),
            mk(OP_APPEND, '0, 7, 0, 0, 0),
            mk(OP_APPEND, '1, 128, 0, 0, 0),
            mk_typed(mk(OP_DELETE, '1, 255, 63, 127, 511), STATUS_OK, NO_CHAMP, 7'd0),
            mk_typed(mk(OP_WRITE, key_pool[2], 0, 0, 0, 0), STATUS_OK, NO_CHAMP, 7'd0),
            mk(OP_WRITE, '1, 0, 63, 0, 0),
            mk(OP_WRITE, '0, 0, 1, 0, 0),
            mk(OP_CHOOSE, '0, 0, 0, 2, 256),
            mk(OP_CHOOSE, '0, 0, 0, 2, 3),
            mk(OP_CHOOSE, '0, 0, 0, 2, 3),
            mk(OP_WRITE, key_pool[2], 0, 0, 0, 0),
            mk(OP_CHOOSE, '0, 0, 0, 1, 255),
            mk(OP_DELETE, '0, 3, 0, 0, 0),
            mk(OP_CHOOSE, '0, 0, 0, 2, 3),
            mk(OP_WRITE, key_pool[2], 0, 0, 0, 0),
            mk(OP_CHOOSE, '0, 0, 0, 2, 0)
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i]);

        // fill one list with a single id and point every slot at it: scores saturate
        for (int i = 0; i < DEPTH; i++)
            send(mk(OP_APPEND, SAT_KEY, 5, 0, 0, 0));
        send(mk_typed(mk(OP_APPEND, SAT_KEY, 5, 0, 0, 0), STATUS_LIST_FULL, NO_CHAMP, 7'd0));
        for (int i = 0; i < SLOTS; i++)
            send(mk(OP_WRITE, SAT_KEY, 0, i, 0, 0));
        send(mk_typed(mk(OP_CHOOSE, '0, 0, 0, 127, 256), STATUS_OK, 9'd5, SCORE_MAX));
        send(mk_typed(mk(OP_CHOOSE, '0, 0, 0, 64, 5), STATUS_OK, NO_CHAMP, 7'd0));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
                want_hold = 1'b1;
            send(random_request());
        end

        // run the hook table out of entries, then one more new print
        for (int i = 0; i < HOOKS; i++)
            if (!m_used[i])
                send(mk(OP_APPEND, 64'hF00D_0000_0000_0000 | i, i, 0, 0, 0));
        send(mk(OP_APPEND, 64'hF00D_FFFF_0000_0000, 1, 0, 0, 0));
        send(mk(OP_CHOOSE, '0, 0, 0, 8, 256));

        in_valid <= 1'b0;
        waited = 0;
        while (awaited.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && awaited.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
